// File: sv/ssp_pkg.sv
// Shared types, codes and helper functions of the size string parser.
package ssp_pkg;

   // Default of the value width.
   localparam int ValueBitsDefault = 64;

   // Byte used as decimal point after reset.
   localparam logic [7:0] DecimalPointReset = 8'd46;

   // Parse phases.
   localparam logic [3:0] PH_WS      = 4'd0;
   localparam logic [3:0] PH_SIGN    = 4'd1;
   localparam logic [3:0] PH_ZERO    = 4'd2;
   localparam logic [3:0] PH_ZEROX   = 4'd3;
   localparam logic [3:0] PH_INT     = 4'd4;
   localparam logic [3:0] PH_FRAC    = 4'd5;
   localparam logic [3:0] PH_TAIL    = 4'd6;
   localparam logic [3:0] PH_TAIL_DP = 4'd7;
   localparam logic [3:0] PH_SUF_I   = 4'd8;
   localparam logic [3:0] PH_SUF_B   = 4'd9;
   localparam logic [3:0] PH_SUF_IB  = 4'd10;
   localparam logic [3:0] PH_ERR     = 4'd11;
   localparam logic [3:0] PH_HOLD    = 4'd12;

   // Radix of the integer part.
   localparam logic [1:0] RAD_DEC = 2'd0;
   localparam logic [1:0] RAD_OCT = 2'd1;
   localparam logic [1:0] RAD_HEX = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_RANGE   = 2'd2;

   // Factors of the shared multiply-add unit.
   localparam logic [2:0] FAC_1    = 3'd0;
   localparam logic [2:0] FAC_8    = 3'd1;
   localparam logic [2:0] FAC_10   = 3'd2;
   localparam logic [2:0] FAC_16   = 3'd3;
   localparam logic [2:0] FAC_100  = 3'd4;
   localparam logic [2:0] FAC_1000 = 3'd5;
   localparam logic [2:0] FAC_1024 = 3'd6;

   // Digit value that marks a byte that is no digit.
   localparam logic [6:0] NotDigit = 7'd99;

   // Control part of the parse state.
   typedef struct packed {
      logic [3:0] phase;
      logic [1:0] radix_sel;
      logic [7:0] frac_zero_count;
      logic [3:0] suffix_exp;
      logic       decimal_units;
      logic [1:0] error_code;
   } ctrl_type;

   localparam ctrl_type CtrlReset = '{
      phase: PH_WS, radix_sel: RAD_DEC, frac_zero_count: 8'd0,
      suffix_exp: 4'd0, decimal_units: 1'b0, error_code: ST_OK};

   // Value of a hex, octal or decimal digit character.
   function automatic logic [6:0] digit_val(input logic [7:0] c);
      logic [6:0] d;
      d = NotDigit;
      if (c >= 8'h30 && c <= 8'h39) d = 7'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) d = 7'(c - 8'h61 + 8'd10);
      else if (c >= 8'h41 && c <= 8'h46) d = 7'(c - 8'h41 + 8'd10);
      return d;
   endfunction

   // Unit power of a suffix letter, zero when it is none.
   function automatic logic [3:0] letter_pow(input logic [7:0] c);
      logic [3:0] p;
      case (c | 8'h20)
         8'h6b: p = 4'd1;
         8'h6d: p = 4'd2;
         8'h67: p = 4'd3;
         8'h74: p = 4'd4;
         8'h70: p = 4'd5;
         8'h65: p = 4'd6;
         8'h7a: p = 4'd7;
         8'h79: p = 4'd8;
         default: p = 4'd0;
      endcase
      return p;
   endfunction

   // Byte over three by a reciprocal multiply, exact for 0..255.
   function automatic logic [6:0] div3(input logic [7:0] z);
      logic [16:0] prod;
      prod = 17'(z) * 17'd171;
      return prod[15:9];
   endfunction

endpackage

// File: sv/ssp_mac.sv
// Shared multiply-by-constant and add unit with overflow detection.
module ssp_mac #(
   parameter int VALUE_BITS = ssp_pkg::ValueBitsDefault
) (
   input  logic [VALUE_BITS-1:0] opnd,
   input  logic [2:0]            factor,
   input  logic [3:0]            addend,
   output logic [VALUE_BITS-1:0] prod,
   output logic                  ovf
);

   localparam int W = VALUE_BITS + 11;

   logic [W-1:0] o;
   logic [W-1:0] wide;

   // Shift-and-add product, kept wide enough to see any overflow.
   always_comb begin
      o = W'(opnd);
      case (factor)
         ssp_pkg::FAC_1:    wide = o;
         ssp_pkg::FAC_8:    wide = o << 3;
         ssp_pkg::FAC_10:   wide = (o << 3) + (o << 1);
         ssp_pkg::FAC_16:   wide = o << 4;
         ssp_pkg::FAC_100:  wide = (o << 6) + (o << 5) + (o << 2);
         ssp_pkg::FAC_1000: wide = (o << 10) - (o << 4) - (o << 3);
         ssp_pkg::FAC_1024: wide = o << 10;
         default:           wide = o;
      endcase
      wide = wide + W'(addend);
   end

   assign prod = wide[VALUE_BITS-1:0];
   assign ovf  = |wide[W-1:VALUE_BITS];

endmodule

// File: sv/ssp_lexer.sv
// Character decoder: next parse state for one string byte.
module ssp_lexer #(
   parameter int VALUE_BITS = ssp_pkg::ValueBitsDefault
) (
   input  logic [7:0]            ch,
   input  logic [7:0]            dp_char,
   input  ssp_pkg::ctrl_type     ctrl,
   input  logic [VALUE_BITS-1:0] int_acc,
   input  logic [VALUE_BITS-1:0] frac_acc,
   output logic [VALUE_BITS-1:0] mac_opnd,
   output logic [2:0]            mac_factor,
   output logic [3:0]            mac_addend,
   input  logic [VALUE_BITS-1:0] mac_prod,
   input  logic                  mac_ovf,
   output ssp_pkg::ctrl_type     ctrl_next,
   output logic [VALUE_BITS-1:0] int_next,
   output logic [VALUE_BITS-1:0] frac_next
);

   logic [6:0] d;
   logic       ws;
   logic       is_b;
   logic [6:0] radix;

   always_comb begin
      d    = ssp_pkg::digit_val(ch);
      ws   = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
      is_b = (ch == 8'h42) || (ch == 8'h62);
      case (ctrl.radix_sel)
         ssp_pkg::RAD_HEX: radix = 7'd16;
         ssp_pkg::RAD_OCT: radix = 7'd8;
         default:          radix = 7'd10;
      endcase
   end

   // The integer part and the fraction each accumulate through the shared unit.
   always_comb begin
      mac_addend = d[3:0];
      if (ctrl.phase == ssp_pkg::PH_INT) begin
         mac_opnd = int_acc;
         case (ctrl.radix_sel)
            ssp_pkg::RAD_HEX: mac_factor = ssp_pkg::FAC_16;
            ssp_pkg::RAD_OCT: mac_factor = ssp_pkg::FAC_8;
            default:          mac_factor = ssp_pkg::FAC_10;
         endcase
      end else begin
         mac_opnd   = frac_acc;
         mac_factor = ssp_pkg::FAC_10;
      end
   end

   // Phase transitions.
   always_comb begin
      ctrl_next = ctrl;
      int_next  = int_acc;
      frac_next = frac_acc;
      case (ctrl.phase)
         ssp_pkg::PH_WS, ssp_pkg::PH_SIGN: begin
            if (ctrl.phase == ssp_pkg::PH_WS && ws) begin
               ctrl_next.phase = ctrl.phase;
            end else if (ctrl.phase == ssp_pkg::PH_WS && ch == 8'h2b) begin
               ctrl_next.phase = ssp_pkg::PH_SIGN;
            end else if (ch == 8'h30) begin
               ctrl_next.phase = ssp_pkg::PH_ZERO;
               int_next = '0;
            end else if (d >= 7'd1 && d <= 7'd9) begin
               ctrl_next.phase     = ssp_pkg::PH_INT;
               ctrl_next.radix_sel = ssp_pkg::RAD_DEC;
               int_next = VALUE_BITS'(d[3:0]);
            end else begin
               ctrl_next.phase      = ssp_pkg::PH_ERR;
               ctrl_next.error_code = ssp_pkg::ST_INVALID;
            end
         end
         ssp_pkg::PH_ZERO, ssp_pkg::PH_INT: begin
            if (ctrl.phase == ssp_pkg::PH_ZERO && (ch == 8'h78 || ch == 8'h58)) begin
               ctrl_next.phase = ssp_pkg::PH_ZEROX;
            end else if (ctrl.phase == ssp_pkg::PH_ZERO && d <= 7'd7) begin
               ctrl_next.phase     = ssp_pkg::PH_INT;
               ctrl_next.radix_sel = ssp_pkg::RAD_OCT;
               int_next = VALUE_BITS'(d[3:0]);
            end else if (ctrl.phase == ssp_pkg::PH_INT && d < radix) begin
               if (mac_ovf) begin
                  ctrl_next.phase      = ssp_pkg::PH_ERR;
                  ctrl_next.error_code = ssp_pkg::ST_RANGE;
               end else begin
                  int_next = mac_prod;
               end
            end else begin
               ctrl_next.suffix_exp = ssp_pkg::letter_pow(ch);
               ctrl_next.phase = (ch == dp_char) ? ssp_pkg::PH_TAIL_DP : ssp_pkg::PH_TAIL;
            end
         end
         ssp_pkg::PH_ZEROX: begin
            if (d < 7'd16) begin
               ctrl_next.phase     = ssp_pkg::PH_INT;
               ctrl_next.radix_sel = ssp_pkg::RAD_HEX;
               int_next = VALUE_BITS'(d[3:0]);
            end else begin
               // The 'x' itself becomes an unknown suffix; this byte follows it.
               ctrl_next.suffix_exp = 4'd0;
               if (ch == 8'h69) begin
                  ctrl_next.phase = ssp_pkg::PH_SUF_I;
               end else if (is_b) begin
                  ctrl_next.phase         = ssp_pkg::PH_SUF_B;
                  ctrl_next.decimal_units = 1'b1;
               end else begin
                  ctrl_next.phase      = ssp_pkg::PH_ERR;
                  ctrl_next.error_code = ssp_pkg::ST_INVALID;
               end
            end
         end
         ssp_pkg::PH_FRAC, ssp_pkg::PH_TAIL, ssp_pkg::PH_TAIL_DP: begin
            if (ctrl.phase != ssp_pkg::PH_FRAC && ch == 8'h69) begin
               ctrl_next.phase = ssp_pkg::PH_SUF_I;
            end else if (ctrl.phase != ssp_pkg::PH_FRAC && is_b) begin
               ctrl_next.phase         = ssp_pkg::PH_SUF_B;
               ctrl_next.decimal_units = 1'b1;
            end else if (ctrl.phase != ssp_pkg::PH_TAIL && d <= 7'd9) begin
               ctrl_next.phase = ssp_pkg::PH_FRAC;
               // Leading zeros of the fraction are only counted.
               if (frac_acc == '0 && d == 7'd0) begin
                  if (ctrl.frac_zero_count != 8'd255)
                     ctrl_next.frac_zero_count = ctrl.frac_zero_count + 8'd1;
               end else if (mac_ovf) begin
                  ctrl_next.phase      = ssp_pkg::PH_ERR;
                  ctrl_next.error_code = ssp_pkg::ST_RANGE;
               end else begin
                  frac_next = mac_prod;
               end
            end else if (ctrl.phase == ssp_pkg::PH_FRAC) begin
               ctrl_next.suffix_exp = ssp_pkg::letter_pow(ch);
               ctrl_next.phase      = ssp_pkg::PH_TAIL;
            end else begin
               ctrl_next.phase      = ssp_pkg::PH_ERR;
               ctrl_next.error_code = ssp_pkg::ST_INVALID;
            end
         end
         ssp_pkg::PH_SUF_I: begin
            if (is_b) begin
               ctrl_next.phase = ssp_pkg::PH_SUF_IB;
            end else begin
               ctrl_next.phase      = ssp_pkg::PH_ERR;
               ctrl_next.error_code = ssp_pkg::ST_INVALID;
            end
         end
         ssp_pkg::PH_SUF_B, ssp_pkg::PH_SUF_IB: begin
            ctrl_next.phase      = ssp_pkg::PH_ERR;
            ctrl_next.error_code = ssp_pkg::ST_INVALID;
         end
         default: begin
            ctrl_next = ctrl;
         end
      endcase
   end

endmodule

// File: sv/size_string_parser.sv
// Top level of the size string parser: registers, finish sequencer and output word.
// Bytes that neither end the string nor are last are taken back to back, with no gap.
// A last byte starts the finish sequencer, which forms the result word: up to 8 scaling
// steps of the integer part and up to 7 of the fraction term, one per cycle through the
// shared multiply-add unit; input is held off meanwhile and while a result waits to go out.
// Reset (synchronous, active high) clears the parse state and sets the decimal point to '.'.
module size_string_parser #(
   parameter int VALUE_BITS = ssp_pkg::ValueBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] ch
   input  logic        req_tlast,  // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // [63:0] value, [67:64] unit_power, [69:68] status
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   localparam logic [2:0] SQ_IDLE    = 3'd0;
   localparam logic [2:0] SQ_FIN     = 3'd1;
   localparam logic [2:0] SQ_SCALE_X = 3'd2;
   localparam logic [2:0] SQ_FRAC    = 3'd3;
   localparam logic [2:0] SQ_SCALE_Y = 3'd4;
   localparam logic [2:0] SQ_SUM     = 3'd5;
   localparam logic [2:0] SQ_OUT     = 3'd6;

   logic [2:0]            sq_ff, sq_in;
   ssp_pkg::ctrl_type     ctrl_ff, ctrl_in, lex_ctrl;
   logic [VALUE_BITS-1:0] int_ff, int_in, lex_int;
   logic [VALUE_BITS-1:0] frac_ff, frac_in, lex_frac;
   logic [7:0]            dp_ff, dp_in;
   logic                  out_pend_ff, out_pend_in;
   logic [VALUE_BITS-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [1:0]            st_ff, st_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [71:0]           rsp_data_ff, rsp_data_in;

   logic [VALUE_BITS-1:0] lex_opnd, mac_opnd, mac_prod;
   logic [2:0]            lex_factor, mac_factor, base_fac;
   logic [3:0]            lex_addend, mac_addend;
   logic                  mac_ovf;
   logic                  accept;
   logic [6:0]            grp;
   logic [7:0]            zr;
   logic                  frac_nz;

   assign req_tready = (sq_ff == SQ_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   ssp_lexer #(.VALUE_BITS(VALUE_BITS)) u_lexer (
      .ch(req_tdata), .dp_char(dp_ff), .ctrl(ctrl_ff),
      .int_acc(int_ff), .frac_acc(frac_ff),
      .mac_opnd(lex_opnd), .mac_factor(lex_factor), .mac_addend(lex_addend),
      .mac_prod(mac_prod), .mac_ovf(mac_ovf),
      .ctrl_next(lex_ctrl), .int_next(lex_int), .frac_next(lex_frac)
   );

   ssp_mac #(.VALUE_BITS(VALUE_BITS)) u_mac (
      .opnd(mac_opnd), .factor(mac_factor), .addend(mac_addend),
      .prod(mac_prod), .ovf(mac_ovf)
   );

   // Fraction group count and remainder from the leading zero count.
   always_comb begin
      grp      = ssp_pkg::div3(ctrl_ff.frac_zero_count);
      zr       = ctrl_ff.frac_zero_count - 8'(grp) * 8'd3;
      frac_nz  = (frac_ff != '0);
      base_fac = ctrl_ff.decimal_units ? ssp_pkg::FAC_1000 : ssp_pkg::FAC_1024;
   end

   // The multiply-add unit serves the sequencer in its scaling and fraction states, the lexer otherwise.
   always_comb begin
      mac_addend = 4'd0;
      case (sq_ff)
         SQ_SCALE_X: begin
            mac_opnd   = sx_ff;
            mac_factor = base_fac;
         end
         SQ_SCALE_Y: begin
            mac_opnd   = sy_ff;
            mac_factor = base_fac;
         end
         SQ_FRAC: begin
            mac_opnd   = frac_ff;
            mac_factor = (zr == 8'd0) ? ssp_pkg::FAC_100 :
                         (zr == 8'd1) ? ssp_pkg::FAC_10 : ssp_pkg::FAC_1;
         end
         default: begin
            mac_opnd   = lex_opnd;
            mac_factor = lex_factor;
            mac_addend = lex_addend;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      sq_in        = sq_ff;
      ctrl_in      = ctrl_ff;
      int_in       = int_ff;
      frac_in      = frac_ff;
      dp_in        = csr_we ? csr_wdata : dp_ff;
      out_pend_in  = out_pend_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      cnt_in       = cnt_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (sq_ff)
         SQ_IDLE: begin
            if (accept) begin
               out_pend_in = req_tlast;
               if (ctrl_ff.phase != ssp_pkg::PH_HOLD) begin
                  if (req_tdata != 8'd0) begin
                     ctrl_in = lex_ctrl;
                     int_in  = lex_int;
                     frac_in = lex_frac;
                  end
                  if (req_tdata == 8'd0 || req_tlast) sq_in = SQ_FIN;
               end else if (req_tlast) begin
                  sq_in = SQ_OUT;
               end
            end
         end
         SQ_FIN: begin
            ctrl_in.phase = ssp_pkg::PH_HOLD;
            sq_in = out_pend_ff ? SQ_OUT : SQ_IDLE;
            case (ctrl_ff.phase)
               ssp_pkg::PH_ZERO, ssp_pkg::PH_INT: begin
                  ctrl_in.suffix_exp = 4'd0;
                  ctrl_in.error_code = ssp_pkg::ST_OK;
               end
               ssp_pkg::PH_ERR: begin
                  int_in = '0;
                  ctrl_in.suffix_exp = 4'd0;
               end
               ssp_pkg::PH_TAIL, ssp_pkg::PH_TAIL_DP, ssp_pkg::PH_SUF_IB,
               ssp_pkg::PH_SUF_B: begin
                  if (ctrl_ff.suffix_exp == 4'd0 ||
                      (frac_nz && 8'(grp) + 8'd1 > 8'(ctrl_ff.suffix_exp))) begin
                     int_in = '0;
                     ctrl_in.suffix_exp = 4'd0;
                     ctrl_in.error_code = ssp_pkg::ST_INVALID;
                  end else begin
                     ctrl_in.phase = ctrl_ff.phase;
                     sx_in  = int_ff;
                     cnt_in = ctrl_ff.suffix_exp;
                     st_in  = ssp_pkg::ST_OK;
                     sq_in  = SQ_SCALE_X;
                  end
               end
               default: begin
                  int_in = '0;
                  ctrl_in.suffix_exp = 4'd0;
                  ctrl_in.error_code = ssp_pkg::ST_INVALID;
               end
            endcase
         end
         SQ_SCALE_X: begin
            // One multiply by the unit base per cycle; stop at the first overflow.
            if (cnt_ff != 4'd0 && !mac_ovf) begin
               sx_in  = mac_prod;
               cnt_in = cnt_ff - 4'd1;
            end else begin
               if (cnt_ff != 4'd0) st_in = ssp_pkg::ST_RANGE;
               sy_in = '0;
               sq_in = frac_nz ? SQ_FRAC : SQ_SUM;
            end
         end
         SQ_FRAC: begin
            sy_in  = mac_prod;
            cnt_in = ctrl_ff.suffix_exp - grp[3:0] - 4'd1;
            sq_in  = SQ_SCALE_Y;
         end
         SQ_SCALE_Y: begin
            if (cnt_ff != 4'd0 && !mac_ovf) begin
               sy_in  = mac_prod;
               cnt_in = cnt_ff - 4'd1;
            end else begin
               sq_in = SQ_SUM;
            end
         end
         SQ_SUM: begin
            int_in = sx_ff + sy_ff;
            ctrl_in.error_code = st_ff;
            ctrl_in.phase = ssp_pkg::PH_HOLD;
            sq_in = out_pend_ff ? SQ_OUT : SQ_IDLE;
         end
         SQ_OUT: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, ctrl_ff.error_code, ctrl_ff.suffix_exp,
                               64'(int_ff)};
               ctrl_in = ssp_pkg::CtrlReset;
               int_in  = '0;
               frac_in = '0;
               sq_in   = SQ_IDLE;
            end
         end
         default: begin
            sq_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff        <= SQ_IDLE;
         ctrl_ff      <= ssp_pkg::CtrlReset;
         int_ff       <= '0;
         frac_ff      <= '0;
         dp_ff        <= ssp_pkg::DecimalPointReset;
         out_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sq_ff        <= sq_in;
         ctrl_ff      <= ctrl_in;
         int_ff       <= int_in;
         frac_ff      <= frac_in;
         dp_ff        <= dp_in;
         out_pend_ff  <= out_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      cnt_ff      <= cnt_in;
      st_ff       <= st_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: sv/ssp_checker.sv
// Port-level checker of the size string parser and its bind.
module ssp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   // A result word waits until it is taken.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // Status is never the unused code.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[69:68] != 2'd3)
      else $error("undefined status code");

   // An invalid string carries neither value nor power.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[69:68] == 2'd1 |-> rsp_tdata[67:0] == 68'd0)
      else $error("invalid result with nonzero payload");

   // Unit power stays within none to Y, and the two top bits are zero.
   a_power: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[67:64] <= 4'd8 && rsp_tdata[71:70] == 2'd0)
      else $error("unit power out of range");

endmodule

bind size_string_parser ssp_checker u_ssp_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
